@@ rtl/lbe_pkg.sv @@
// Shared types and constants for the lattice bending energy block.
`default_nettype none
package lbe_pkg;

    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int ENERGY_W   = 63;
    localparam int ACC_W      = 64;
    localparam int DRAIN_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LAST_COLUMN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW    = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE = 6'd63;

    // Cycles between the last read of a pass and a settled accumulator.
    localparam logic [DRAIN_W-1:0] DRAIN_CYCLES = 3'd4;

    typedef logic [1:0] lbe_slot_t;

    // Which lattice column a pass read fetches, relative to the current point.
    localparam lbe_slot_t SLOT_COL   = 2'd0;
    localparam lbe_slot_t SLOT_PREV  = 2'd1;
    localparam lbe_slot_t SLOT_PREV2 = 2'd2;

    typedef struct packed {
        logic      vld;
        lbe_slot_t slot;
        logic      i_ge1;
        logic      i_ge2;
        logic      j_ge1;
        logic      j_ge2;
    } lbe_rd_tag_t;

    typedef struct packed {
        logic vld;
        logic twist;
    } lbe_term_ctl_t;

    typedef struct packed {
        logic acc_clear;
        logic out_load;
    } lbe_seq_ctl_t;

endpackage
`default_nettype wire

@@ rtl/lbe_point_mem.sv @@
// Point store: one write port, one read port with registered read data.
`default_nettype none
module lbe_point_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/lbe_sequencer.sv @@
// Configuration registers, load addressing and the read sequence of the energy pass.
`default_nettype none
module lbe_sequencer #(
    parameter int MAX_SIDE = 64,
    parameter int IW       = 6,
    parameter int AW       = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_accept,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lbe_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [lbe_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                          out_free,
    output logic                               s_ready,
    output logic      [AW-1:0]                 wr_addr,
    output logic                               rd_en,
    output logic      [AW-1:0]                 rd_addr,
    output lbe_pkg::lbe_rd_tag_t               rd_tag,
    output lbe_pkg::lbe_seq_ctl_t              seq_ctl
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PASS  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [lbe_pkg::CFG_DATA_W-1:0]     col_cfg_reg, col_cfg_next;
    logic [lbe_pkg::CFG_DATA_W-1:0]     row_cfg_reg, row_cfg_next;
    logic [IW-1:0]                      li_reg, li_next, lj_reg, lj_next;
    logic [AW-1:0]                      la_reg, la_next;
    logic [IW-1:0]                      pi_reg, pi_next, pj_reg, pj_next;
    logic [AW-1:0]                      pa_reg, pa_next;
    lbe_pkg::lbe_slot_t                 phase_reg, phase_next;
    logic [lbe_pkg::DRAIN_W-1:0]        drain_reg, drain_next;
    lbe_pkg::lbe_rd_tag_t               tag_reg, tag_next;
    logic [IW-1:0]                      m_eff, n_eff;
    logic [AW-1:0]                      rows, addr_prev, addr_prev2;
    logic                               i_ge1, i_ge2;

    assign m_eff = (32'(col_cfg_reg) > MAX_SIDE - 1) ? IW'(MAX_SIDE - 1) : IW'(col_cfg_reg);
    assign n_eff = (32'(row_cfg_reg) > MAX_SIDE - 1) ? IW'(MAX_SIDE - 1) : IW'(row_cfg_reg);
    assign rows  = AW'(n_eff) + AW'(1);

    assign i_ge1      = (pi_reg != '0);
    assign i_ge2      = (pi_reg > IW'(1));
    assign addr_prev  = i_ge1 ? pa_reg - rows : pa_reg;
    assign addr_prev2 = i_ge2 ? pa_reg - (rows << 1) : pa_reg;

    assign s_ready = (state_reg == ST_LOAD);
    assign wr_addr = la_reg;
    assign rd_en   = (state_reg == ST_PASS);
    assign rd_tag  = tag_reg;

    always_comb begin
        case (phase_reg)
            lbe_pkg::SLOT_PREV:  rd_addr = addr_prev;
            lbe_pkg::SLOT_PREV2: rd_addr = addr_prev2;
            default:             rd_addr = pa_reg;
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        col_cfg_next      = col_cfg_reg;
        row_cfg_next      = row_cfg_reg;
        li_next           = li_reg;
        lj_next           = lj_reg;
        la_next           = la_reg;
        pi_next           = pi_reg;
        pj_next           = pj_reg;
        pa_next           = pa_reg;
        phase_next        = phase_reg;
        drain_next        = drain_reg;
        seq_ctl.acc_clear = 1'b0;
        seq_ctl.out_load  = 1'b0;

        tag_next.vld   = (state_reg == ST_PASS);
        tag_next.slot  = phase_reg;
        tag_next.i_ge1 = i_ge1;
        tag_next.i_ge2 = i_ge2;
        tag_next.j_ge1 = (pj_reg != '0);
        tag_next.j_ge2 = (pj_reg > IW'(1));

        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                lbe_pkg::CFG_LAST_COLUMN: col_cfg_next = cfg_wr_data;
                lbe_pkg::CFG_LAST_ROW:    row_cfg_next = cfg_wr_data;
                default:                  col_cfg_next = col_cfg_reg;
            endcase
            li_next = '0;
            lj_next = '0;
            la_next = '0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (li_reg == m_eff && lj_reg == n_eff) begin
                        li_next           = '0;
                        lj_next           = '0;
                        la_next           = '0;
                        pi_next           = '0;
                        pj_next           = '0;
                        pa_next           = '0;
                        phase_next        = lbe_pkg::SLOT_COL;
                        seq_ctl.acc_clear = 1'b1;
                        state_next        = ST_PASS;
                    end else begin
                        la_next = la_reg + AW'(1);
                        if (lj_reg == n_eff) begin
                            lj_next = '0;
                            li_next = li_reg + IW'(1);
                        end else begin
                            lj_next = lj_reg + IW'(1);
                        end
                    end
                end
            end
            ST_PASS: begin
                if (phase_reg == lbe_pkg::SLOT_PREV2) begin
                    phase_next = lbe_pkg::SLOT_COL;
                    pa_next    = pa_reg + AW'(1);
                    if (pj_reg == n_eff) begin
                        pj_next = '0;
                        pi_next = pi_reg + IW'(1);
                    end else begin
                        pj_next = pj_reg + IW'(1);
                    end
                    if (pi_reg == m_eff && pj_reg == n_eff) begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                end else begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + lbe_pkg::DRAIN_W'(1);
                if (drain_reg == lbe_pkg::DRAIN_CYCLES - lbe_pkg::DRAIN_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    seq_ctl.out_load = 1'b1;
                    state_next       = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            col_cfg_reg <= lbe_pkg::CFG_RESET_VALUE;
            row_cfg_reg <= lbe_pkg::CFG_RESET_VALUE;
            li_reg      <= '0;
            lj_reg      <= '0;
            la_reg      <= '0;
            pi_reg      <= '0;
            pj_reg      <= '0;
            pa_reg      <= '0;
            phase_reg   <= lbe_pkg::SLOT_COL;
            drain_reg   <= '0;
            tag_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            col_cfg_reg <= col_cfg_next;
            row_cfg_reg <= row_cfg_next;
            li_reg      <= li_next;
            lj_reg      <= lj_next;
            la_reg      <= la_next;
            pi_reg      <= pi_next;
            pj_reg      <= pj_next;
            pa_reg      <= pa_next;
            phase_reg   <= phase_next;
            drain_reg   <= drain_next;
            tag_reg     <= tag_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/lbe_diff_unit.sv @@
// Neighbor window and second-difference and twist vectors from the read stream.
`default_nettype none
module lbe_diff_unit #(
    parameter int CB = 16,
    parameter int DW = 18
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [3*CB-1:0]        rd_data,
    input  wire lbe_pkg::lbe_rd_tag_t   rd_tag,
    output logic      [3*DW-1:0]        diff_vec,
    output lbe_pkg::lbe_term_ctl_t      diff_ctl
);

    logic [CB-1:0]        c0_reg [3];
    logic [CB-1:0]        c1_reg [3];
    logic [CB-1:0]        p0_reg [3];
    logic [3*DW-1:0]      diff_reg, diff_next;
    lbe_pkg::lbe_term_ctl_t ctl_reg, ctl_next;

    function automatic logic signed [DW-1:0] sx(input logic [CB-1:0] v);
        return {{(DW - CB){v[CB-1]}}, v};
    endfunction

    always_comb begin
        logic signed [DW-1:0] d, ec0, ec1, ep0, r;
        ctl_next = '0;
        for (int k = 0; k < 3; k++) begin
            d   = sx(rd_data[k*CB +: CB]);
            ec0 = sx(c0_reg[k]);
            ec1 = sx(c1_reg[k]);
            ep0 = sx(p0_reg[k]);
            case (rd_tag.slot)
                lbe_pkg::SLOT_COL:   r = d + ec1 - (ec0 <<< 1);
                lbe_pkg::SLOT_PREV:  r = ec0 + ep0 - ec1 - d;
                default:             r = ec0 + d - (ep0 <<< 1);
            endcase
            diff_next[k*DW +: DW] = r;
        end
        case (rd_tag.slot)
            lbe_pkg::SLOT_COL: begin
                ctl_next.vld = rd_tag.vld && rd_tag.j_ge2;
            end
            lbe_pkg::SLOT_PREV: begin
                ctl_next.vld   = rd_tag.vld && rd_tag.i_ge1 && rd_tag.j_ge1;
                ctl_next.twist = 1'b1;
            end
            default: begin
                ctl_next.vld = rd_tag.vld && rd_tag.i_ge2;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        if (rd_tag.vld) begin
            for (int k = 0; k < 3; k++) begin
                case (rd_tag.slot)
                    lbe_pkg::SLOT_COL: begin
                        c0_reg[k] <= rd_data[k*CB +: CB];
                        c1_reg[k] <= c0_reg[k];
                    end
                    lbe_pkg::SLOT_PREV: begin
                        p0_reg[k] <= rd_data[k*CB +: CB];
                    end
                    default: begin
                        p0_reg[k] <= p0_reg[k];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    assign diff_vec = diff_reg;
    assign diff_ctl = ctl_reg;

endmodule
`default_nettype wire

@@ rtl/lbe_accum.sv @@
// Squares the difference vectors and keeps the saturating energy sum.
`default_nettype none
module lbe_accum #(
    parameter int DW = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [3*DW-1:0]               diff_vec,
    input  wire lbe_pkg::lbe_term_ctl_t        diff_ctl,
    input  wire logic                          acc_clear,
    output logic      [lbe_pkg::ENERGY_W-1:0]  energy,
    output logic                               saturated
);

    localparam int SQW = 2 * DW - 1;
    localparam int TW  = SQW + 3;

    logic [SQW-1:0]              sq_reg [3];
    lbe_pkg::lbe_term_ctl_t      sq_ctl_reg;
    logic [TW-1:0]               term_reg, term_next, sum3;
    logic                        term_vld_reg;
    logic [lbe_pkg::ENERGY_W-1:0] sum_reg;
    logic                        sat_reg;
    logic [lbe_pkg::ACC_W-1:0]   acc_next;
    logic signed [2*DW-1:0]      prod [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = $signed(diff_vec[k*DW +: DW]) * $signed(diff_vec[k*DW +: DW]);
        end
    end

    assign sum3      = TW'(sq_reg[0]) + TW'(sq_reg[1]) + TW'(sq_reg[2]);
    assign term_next = sq_ctl_reg.twist ? (sum3 << 1) : sum3;
    assign acc_next  = {1'b0, sum_reg} + lbe_pkg::ACC_W'(term_reg);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            sq_reg[k] <= prod[k][SQW-1:0];
        end
        term_reg <= term_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_ctl_reg   <= '0;
            term_vld_reg <= 1'b0;
            sum_reg      <= '0;
            sat_reg      <= 1'b0;
        end else begin
            sq_ctl_reg   <= diff_ctl;
            term_vld_reg <= sq_ctl_reg.vld;
            if (acc_clear) begin
                sum_reg <= '0;
                sat_reg <= 1'b0;
            end else if (term_vld_reg) begin
                if (acc_next[lbe_pkg::ACC_W-1]) begin
                    sum_reg <= '1;
                    sat_reg <= 1'b1;
                end else begin
                    sum_reg <= acc_next[lbe_pkg::ENERGY_W-1:0];
                end
            end
        end
    end

    assign energy    = sum_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

@@ rtl/lattice_bending_energy.sv @@
// Top level of the lattice bending energy block.
//
//  Channel | Direction | Contents
//  s_      | in        | one control point per transaction
//  m_      | out       | total energy and saturation flag, one per lattice
//  cfg_    | in        | write of last_column_index (0) or last_row_index (1)
//
// Points are stored at one per cycle while the block is loading; s_tready is low
// through the pass, drain and hand-off. After the last point the pass reads the
// single memory read port three times per point, then drains the pipeline and
// hands the result off.
// Reset is synchronous and active low; the point store is not cleared.
// A result waiting on m_tready holds the next pass in its final cycle only.
`default_nettype none
module lattice_bending_energy #(
    parameter int MAX_SIDE   = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // coord_x, coord_y, coord_z, then zero padding
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // bending_energy[62:0], energy_saturated[63]
    output logic      [63:0]                          m_tdata,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [lbe_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  wire logic [lbe_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

    localparam int IW    = $clog2(MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 3 * COORD_BITS;
    localparam int DW    = COORD_BITS + 2;

    logic                          s_accept, out_free;
    logic [AW-1:0]                 wr_addr, rd_addr;
    logic                          rd_en;
    logic [PW-1:0]                 rd_data;
    lbe_pkg::lbe_rd_tag_t          rd_tag;
    lbe_pkg::lbe_seq_ctl_t         seq_ctl;
    logic [3*DW-1:0]               diff_vec;
    lbe_pkg::lbe_term_ctl_t        diff_ctl;
    logic [lbe_pkg::ENERGY_W-1:0]  energy;
    logic                          saturated;
    logic                          out_vld_reg;
    logic [lbe_pkg::ENERGY_W-1:0]  out_energy_reg;
    logic                          out_sat_reg;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    lbe_sequencer #(
        .MAX_SIDE (MAX_SIDE),
        .IW       (IW),
        .AW       (AW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_accept     (s_accept),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .out_free     (out_free),
        .s_ready      (s_tready),
        .wr_addr      (wr_addr),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_tag       (rd_tag),
        .seq_ctl      (seq_ctl)
    );

    lbe_point_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[PW-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lbe_diff_unit #(
        .CB (COORD_BITS),
        .DW (DW)
    ) u_diff (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_data  (rd_data),
        .rd_tag   (rd_tag),
        .diff_vec (diff_vec),
        .diff_ctl (diff_ctl)
    );

    lbe_accum #(
        .DW (DW)
    ) u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .diff_vec  (diff_vec),
        .diff_ctl  (diff_ctl),
        .acc_clear (seq_ctl.acc_clear),
        .energy    (energy),
        .saturated (saturated)
    );

    always_ff @(posedge aclk) begin
        if (seq_ctl.out_load) begin
            out_energy_reg <= energy;
            out_sat_reg    <= saturated;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (seq_ctl.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_sat_reg, out_energy_reg};

endmodule
`default_nettype wire

@@ rtl/lbe_checker.sv @@
// Port-level checks for the lattice bending energy block and their binding.
`default_nettype none
module lbe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // The result register is empty after reset.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A held result must not change.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A new result comes only out of a pass, while loading is closed.
    a_result_after_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while points were loading");

    // A clipped energy reads as the full-scale value.
    a_sat_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[63] |-> m_tdata[62:0] == 63'h7FFF_FFFF_FFFF_FFFF)
        else $error("saturation flag without full-scale energy");

    // A result never follows an input transaction directly; a pass lies between them.
    a_no_result_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after an input transaction");

endmodule

bind lattice_bending_energy lbe_checker u_lbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ dv/tb_lattice_bending_energy.sv @@
// Self-checking testbench for lattice_bending_energy: streams lattices and checks each energy.
module tb_lattice_bending_energy;

    localparam int MAX_SIDE         = 64;
    localparam int COORD_BITS       = 16;
    localparam int STORE_DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int DATA_W           = ((3*COORD_BITS+7)/8)*8;
    localparam int RANDOM_ITEMS     = 1450;
    localparam int RESET_PART_ITEMS = 128;
    localparam int SETTLE_CYCLES    = 16;
    localparam int HOLD_CYCLES      = 600;
    localparam longint unsigned ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_MAX = 16'sh7FFF;
    localparam coord_t COORD_MIN = 16'sh8000;
    localparam coord_t COORD_ONE = 16'sh4000;

    // Same layout as m_tdata.
    typedef struct packed {
        logic                         sat;
        logic [lbe_pkg::ENERGY_W-1:0] energy;
    } energy_res_t;

    typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [lbe_pkg::CFG_IDX_W-1:0]  idx;
        logic [lbe_pkg::CFG_DATA_W-1:0] val;
        coord_t                         x;
        coord_t                         y;
        coord_t                         z;
        logic                           typed;
        logic [lbe_pkg::ENERGY_W-1:0]   energy;
    } stim_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    // coord_x, coord_y, coord_z
    logic [DATA_W-1:0]              s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    // bending_energy[62:0], energy_saturated[63]
    logic [63:0]                    m_tdata;
    logic                           cfg_wr_en;
    logic [lbe_pkg::CFG_IDX_W-1:0]  cfg_wr_index;
    logic [lbe_pkg::CFG_DATA_W-1:0] cfg_wr_data;

    int                             lattice_pts [STORE_DEPTH][3];
    int                             pts_loaded = 0;
    logic [lbe_pkg::CFG_DATA_W-1:0] col_reg = lbe_pkg::CFG_RESET_VALUE;
    logic [lbe_pkg::CFG_DATA_W-1:0] row_reg = lbe_pkg::CFG_RESET_VALUE;
    energy_res_t                    energy_expected [$];
    int                             errors = 0;
    int                             points_sent = 0;
    bit                             quiet_tail = 1'b0;
    bit                             hold_off_req = 1'b0;

    lattice_bending_energy #(
        .MAX_SIDE  (MAX_SIDE),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Squared length of a + b - c - d over the three coordinates.
    function automatic longint unsigned combo_sq(int a, int b, int c, int d);
        longint unsigned s;
        longint          e;
        int              k;
        s = 0;
        for (k = 0; k < 3; k++) begin
            e = longint'(lattice_pts[a][k]) + lattice_pts[b][k] - lattice_pts[c][k]
                - lattice_pts[d][k];
            s += longint'(e * e);
        end
        return s;
    endfunction

    function automatic energy_res_t lattice_energy(int m, int n);
        longint unsigned acc;
        longint unsigned t [4];
        bit              use_t [4];
        logic            clip;
        int              i, j, q, c, rows;
        energy_res_t     r;
        acc  = 0;
        clip = 1'b0;
        rows = n + 1;
        for (i = 0; i <= m; i++) begin
            for (j = 0; j <= n; j++) begin
                c = i * rows + j;
                use_t[0] = i > 0 && i < m;
                use_t[1] = j > 0 && j < n;
                use_t[2] = i > 0 && j > 0;
                use_t[3] = i < m && j < n;
                t[0] = use_t[0] ? combo_sq(c + rows, c - rows, c, c) : 0;
                t[1] = use_t[1] ? combo_sq(c + 1, c - 1, c, c) : 0;
                t[2] = use_t[2] ? combo_sq(c, c - rows - 1, c - 1, c - rows) : 0;
                t[3] = use_t[3] ? combo_sq(c, c + rows + 1, c + 1, c + rows) : 0;
                for (q = 0; q < 4; q++) begin
                    if (use_t[q]) begin
                        if (acc > ENERGY_MAX - t[q]) begin
                            acc  = ENERGY_MAX;
                            clip = 1'b1;
                        end else begin
                            acc += t[q];
                        end
                    end
                end
            end
        end
        r.energy = acc[lbe_pkg::ENERGY_W-1:0];
        r.sat    = clip;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [lbe_pkg::CFG_IDX_W-1:0] idx,
                                          logic [lbe_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.val   = val;
        return row;
    endfunction

    function automatic stim_row_t pt_row(coord_t x, coord_t y, coord_t z, logic typed,
                                         logic [lbe_pkg::ENERGY_W-1:0] energy);
        stim_row_t row;
        row        = '0;
        row.kind   = ROW_POINT;
        row.x      = x;
        row.y      = y;
        row.z      = z;
        row.typed  = typed;
        row.energy = energy;
        return row;
    endfunction

    function automatic coord_t corner_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return '1;
            default: return coord_t'(1);
        endcase
    endfunction

    // Offers one point and updates the predicted lattice once it is accepted.
    task automatic send_point(coord_t x, coord_t y, coord_t z, logic typed,
                              logic [lbe_pkg::ENERGY_W-1:0] typed_energy);
        int          m, n, total, a;
        energy_res_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'({z, y, x});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        points_sent++;
        m     = (col_reg > MAX_SIDE - 1) ? MAX_SIDE - 1 : col_reg;
        n     = (row_reg > MAX_SIDE - 1) ? MAX_SIDE - 1 : row_reg;
        total = (m + 1) * (n + 1);
        a     = pts_loaded;
        if (a >= total || a >= STORE_DEPTH) a = 0;
        lattice_pts[a][0] = x;
        lattice_pts[a][1] = y;
        lattice_pts[a][2] = z;
        a++;
        if (a < total) begin
            pts_loaded = a;
        end else begin
            pts_loaded = 0;
            r = lattice_energy(m, n);
            if (typed) begin
                r.sat    = 1'b0;
                r.energy = typed_energy;
            end
            energy_expected = {energy_expected, r};
        end
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Register writes wait until the block has delivered everything and settled.
    task automatic write_reg(logic [lbe_pkg::CFG_IDX_W-1:0] idx,
                             logic [lbe_pkg::CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (energy_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == lbe_pkg::CFG_LAST_COLUMN) begin
            col_reg = val;
        end else begin
            row_reg = val;
        end
        pts_loaded = 0;
    endtask

    task automatic send_lattice(int npts, int rows, bit gaps);
        int     mode, p, i, j;
        coord_t bx, by, bz, x, y, z;
        mode = $urandom_range(0, 2);
        bx   = coord_t'($urandom);
        by   = coord_t'($urandom);
        bz   = coord_t'($urandom);
        for (p = 0; p < npts; p++) begin
            i = p / rows;
            j = p % rows;
            if (gaps && !quiet_tail && $urandom_range(0, 99) < 15) begin
                pause_sender($urandom_range(1, 18));
            end
            case (mode)
                0: begin
                    x = coord_t'($urandom);
                    y = coord_t'($urandom);
                    z = coord_t'($urandom);
                end
                1: begin
                    x = corner_coord();
                    y = corner_coord();
                    z = corner_coord();
                end
                default: begin
                    x = bx + coord_t'(i * 301 - j * 17) + coord_t'($urandom_range(0, 63));
                    y = by + coord_t'(j * 257 + i * 5) + coord_t'($urandom_range(0, 63));
                    z = bz + coord_t'(i * j * 29) + coord_t'($urandom_range(0, 63));
                end
            endcase
            send_point(x, y, z, 1'b0, '0);
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 99) < 40) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        energy_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (energy_expected.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result: energy %0d, saturated %0d", got.energy, got.sat);
                end
            end else begin
                want = energy_expected.pop_front();
                if (got.energy !== want.energy || got.sat !== want.sat) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Energy mismatch: expected %0d/%0d, got %0d/%0d",
                                 want.energy, want.sat, got.energy, got.sat);
                    end
                end
            end
        end
    end

    initial begin
        stim_row_t dir_rows [$];
        int        m, n, r, total, lattices, rand_base, wait_cycles;
        bit        gaps;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= lbe_pkg::CFG_LAST_COLUMN;
        cfg_wr_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Part of a lattice at the sizes left by reset; it yields no result and the
        // first register write drops it.
        send_lattice(RESET_PART_ITEMS, int'(lbe_pkg::CFG_RESET_VALUE) + 1, 1'b1);

        // A single-point lattice yields zero energy for every point.
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_COLUMN, 6'd0)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_ROW, 6'd0)};
        dir_rows = {dir_rows, pt_row(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 63'd0)};
        dir_rows = {dir_rows, pt_row(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 63'd0)};
        // A single cell at full swing: only the twist term, counted twice.
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_COLUMN, 6'd1)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_ROW, 6'd1)};
        dir_rows = {dir_rows, pt_row(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1,
                                     63'd103076069400)};
        // A partly loaded lattice is dropped by a register write.
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_COLUMN, 6'd2)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_ROW, 6'd0)};
        dir_rows = {dir_rows, pt_row(16'sh1234, 16'sh5678, 16'sh1ABC, 1'b0, '0)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_COLUMN, 6'd2)};
        dir_rows = {dir_rows, pt_row('0, '0, '0, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(COORD_ONE, '0, '0, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row('0, '0, '0, 1'b1, 63'd1073741824)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_COLUMN, 6'd0)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_ROW, 6'd2)};
        dir_rows = {dir_rows, pt_row('0, '0, '0, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row('0, '0, -COORD_ONE, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row('0, '0, '0, 1'b1, 63'd1073741824)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_COLUMN, 6'd2)};
        dir_rows = {dir_rows, cfg_row(lbe_pkg::CFG_LAST_ROW, 6'd2)};
        dir_rows = {dir_rows, pt_row(COORD_MAX, COORD_MIN, '0, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(16'sh0001, 16'shFFFF, COORD_ONE, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(COORD_MIN, COORD_MAX, 16'shC000, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(16'sh0101, 16'shFEFE, 16'sh2AAA, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row('0, '0, '0, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(16'sh5555, 16'shAAAA, 16'sh0001, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(16'shFFFE, 16'sh0002, 16'sh1000, 1'b0, '0)};
        dir_rows = {dir_rows, pt_row(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, '0)};
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_reg(dir_rows[k].idx, dir_rows[k].val);
            end else begin
                send_point(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].typed,
                           dir_rows[k].energy);
            end
        end

        // Results are held back while small lattices keep arriving, so the input stalls.
        write_reg(lbe_pkg::CFG_LAST_COLUMN, 6'd2);
        write_reg(lbe_pkg::CFG_LAST_ROW, 6'd2);
        hold_off_req = 1'b1;
        repeat (6) send_lattice(9, 3, 1'b0);

        rand_base = points_sent;
        while (points_sent - rand_base < RANDOM_ITEMS) begin
            quiet_tail = (points_sent - rand_base) > RANDOM_ITEMS * 85 / 100;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                m = 63;
                n = $urandom_range(0, 2);
            end else if (r < 10) begin
                m = $urandom_range(0, 2);
                n = 63;
            end else begin
                m = $urandom_range(0, 7);
                n = $urandom_range(0, 7);
            end
            if ($urandom_range(0, 1)) begin
                write_reg(lbe_pkg::CFG_LAST_COLUMN, lbe_pkg::CFG_DATA_W'(m));
                write_reg(lbe_pkg::CFG_LAST_ROW, lbe_pkg::CFG_DATA_W'(n));
            end else begin
                write_reg(lbe_pkg::CFG_LAST_ROW, lbe_pkg::CFG_DATA_W'(n));
                write_reg(lbe_pkg::CFG_LAST_COLUMN, lbe_pkg::CFG_DATA_W'(m));
            end
            total    = (m + 1) * (n + 1);
            lattices = (total > 64) ? 1 : $urandom_range(1, 3);
            gaps     = $urandom_range(0, 3) != 0;
            repeat (lattices) begin
                if ($urandom_range(0, 9) == 0) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (energy_expected.size() != 0) @(posedge aclk);
                end
                send_lattice(total, n + 1, gaps);
            end
            if (total > 1 && $urandom_range(0, 6) == 0) begin
                send_lattice($urandom_range(1, total - 1), n + 1, gaps);
            end
        end

        s_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 100000 && energy_expected.size() != 0;
             wait_cycles++) begin
            @(posedge aclk);
        end
        repeat (64) @(posedge aclk);
        if (energy_expected.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", energy_expected.size());
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/lbe_pkg.sv
rtl/lbe_point_mem.sv
rtl/lbe_sequencer.sv
rtl/lbe_diff_unit.sv
rtl/lbe_accum.sv
rtl/lattice_bending_energy.sv
rtl/lbe_checker.sv
dv/tb_lattice_bending_energy.sv
